// ===== rtl/jlf_pkg.sv =====
// Shared types and constants for the joint link framer.
// Used by every module of the block; depends on nothing.
package jlf_pkg;

  localparam logic [1:0] MODE_RX     = 2'd0;
  localparam logic [1:0] MODE_TORQUE = 2'd1;
  localparam logic [1:0] MODE_SEND   = 2'd2;

  localparam logic       KIND_TX  = 1'b0;
  localparam logic       KIND_POS = 1'b1;

  localparam logic [7:0] FRAME_HEADER = 8'h41;
  localparam logic [9:0] POS_MAX      = 10'd1023;
  localparam int         FRAME_BYTES  = 6;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         rx_byte;
    logic [1:0]         joint;
    logic signed [15:0] torque;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [9:0] pos_a;
    logic [9:0] pos_b;
    logic [9:0] pos_c;
    logic [9:0] pos_d;
  } out_t;

  // One unit of work for the back end: a position report or a frame to send,
  // with the four 10-bit values it carries.
  typedef struct packed {
    logic            send;
    logic [3:0][9:0] val;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/jlf_front.sv =====
// Front end: deframes received bytes, applies torque commands and turns
// completed frames and send requests into jobs. Depends on jlf_pkg.
module jlf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  jlf_pkg::in_t  item,
  output logic          push,
  output jlf_pkg::job_t job
);

  logic [2:0]       rx_count;
  logic [2:0]       rx_count_next;
  logic [7:0]       rx_hold [4];
  logic [3:0][9:0]  position;
  logic [3:0][9:0]  position_next;
  logic [3:0][9:0]  command;
  logic [1:0]       hold_idx;
  logic             hold_we;
  logic             frame_done;
  logic signed [17:0] diff;
  logic [9:0]       sat;

  assign hold_idx = 2'(rx_count - 3'd1);

  always_comb begin
    rx_count_next = rx_count;
    hold_we       = 1'b0;
    frame_done    = 1'b0;
    if (rx_count inside {[3'd1:3'd4]}) begin
      rx_count_next = rx_count + 3'd1;
      hold_we       = 1'b1;
    end else if (rx_count == 3'd5) begin
      rx_count_next = 3'd0;
      frame_done    = 1'b1;
    end else begin
      rx_count_next = (item.rx_byte == jlf_pkg::FRAME_HEADER) ? 3'd1 : 3'd0;
    end
  end

  // The low bits of joint 0 sit at the top of the packed byte.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      position_next[i] = {rx_hold[i], item.rx_byte[7 - 2 * i -: 2]};
    end
  end

  always_comb begin
    diff = $signed({8'd0, position[item.joint]}) - 18'(item.torque);
    if (diff < 0) begin
      sat = 10'd0;
    end else if (diff > $signed({8'd0, jlf_pkg::POS_MAX})) begin
      sat = jlf_pkg::POS_MAX;
    end else begin
      sat = diff[9:0];
    end
  end

  always_comb begin
    push     = 1'b0;
    job.send = 1'b0;
    job.val  = position_next;
    if (take) begin
      case (item.mode)
        jlf_pkg::MODE_RX: begin
          push = frame_done;
        end
        jlf_pkg::MODE_SEND: begin
          push     = 1'b1;
          job.send = 1'b1;
          job.val  = command;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= 3'd0;
      position <= '0;
      command  <= '0;
    end else if (take) begin
      case (item.mode)
        jlf_pkg::MODE_RX: begin
          rx_count <= rx_count_next;
          if (frame_done) begin
            position <= position_next;
          end
        end
        jlf_pkg::MODE_TORQUE: begin
          command[item.joint] <= sat;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.mode == jlf_pkg::MODE_RX && hold_we) begin
      rx_hold[hold_idx] <= item.rx_byte;
    end
  end

endmodule

// ===== rtl/jlf_queue.sv =====
// Short job queue between the front and back ends.
// Depends on jlf_pkg for the job and status types.
module jlf_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jlf_pkg::job_t      push_job,
  input  logic               pop,
  output jlf_pkg::job_t      head_job,
  output jlf_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jlf_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_job     = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/jlf_back.sv =====
// Back end: plays out one job at a time, a single report word or the six
// bytes of a frame. Depends on jlf_pkg.
module jlf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_avail,
  input  jlf_pkg::job_t head_job,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_ready,
  output jlf_pkg::out_t result
);

  jlf_pkg::job_t cur;
  logic          busy;
  logic [2:0]    idx;
  logic          at_last;

  assign at_last      = !cur.send || (idx == 3'(jlf_pkg::FRAME_BYTES - 1));
  assign pop          = job_avail && (!busy || (result_ready && at_last));
  assign result_valid = busy;

  always_comb begin
    result = '0;
    if (!cur.send) begin
      result.kind  = jlf_pkg::KIND_POS;
      result.pos_a = cur.val[0];
      result.pos_b = cur.val[1];
      result.pos_c = cur.val[2];
      result.pos_d = cur.val[3];
    end else begin
      result.kind = jlf_pkg::KIND_TX;
      case (idx)
        3'd0: result.tx_byte = jlf_pkg::FRAME_HEADER;
        3'd1: result.tx_byte = cur.val[0][9:2];
        3'd2: result.tx_byte = cur.val[1][9:2];
        3'd3: result.tx_byte = cur.val[2][9:2];
        3'd4: result.tx_byte = cur.val[3][9:2];
        default: begin
          result.tx_byte = {cur.val[0][1:0], cur.val[1][1:0],
                            cur.val[2][1:0], cur.val[3][1:0]};
          result.last    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (busy && result_ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

endmodule

// ===== rtl/joint_link_framer_top.sv =====
// Top level of the joint link framer: front end, job queue and back end.
// Depends on jlf_pkg, jlf_front, jlf_queue and jlf_back.

// The block takes one input word per cycle as long as its job queue of
// QUEUE_DEPTH entries has room; received bytes and torque commands are done
// in the cycle they are taken. A completed frame yields one position report
// word and a send request yields six byte words, which the back end plays
// out at one word per cycle when the output side is ready, so a run of send
// requests is limited by the output port, six words per request.
module joint_link_framer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  jlf_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output jlf_pkg::out_t result
);

  logic               take;
  logic               push;
  logic               pop;
  jlf_pkg::job_t      push_job;
  jlf_pkg::job_t      head_job;
  jlf_pkg::q_status_t q_status;

  assign item_ready = !q_status.full;
  assign take       = item_valid && item_ready;

  jlf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .push (push),
    .job  (push_job)
  );

  jlf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  jlf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_avail    (!q_status.empty),
    .head_job     (head_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_status.empty))
    else $error("job popped from an empty queue");

  a_last_only_on_tx: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (result.kind == jlf_pkg::KIND_TX))
    else $error("last marked on a position report");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == jlf_pkg::KIND_POS) |->
      (result.tx_byte == 8'd0 && !result.last))
    else $error("position report carries transmit fields");
`endif

endmodule

// ===== tb/tb_joint_link_framer_top.sv =====
// Self-checking testbench for joint_link_framer_top: directed rows, then random traffic,
// each result word checked against a behavioral copy of the framer and deframer.
// Depends on jlf_pkg and the joint_link_framer_top RTL.
module tb_joint_link_framer_top;

  localparam int         RANDOM_ITEMS = 146;
  localparam int         MAX_REPORTS  = 10;
  localparam int         DRAIN_CYCLES = 40;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  typedef struct packed {
    logic          typed;
    jlf_pkg::out_t res;
  } row_check_t;

  typedef struct packed {
    jlf_pkg::in_t  w;
    logic          typed;
    jlf_pkg::out_t res;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          item_valid = 1'b0;
  logic          item_ready;
  jlf_pkg::in_t  item = '0;
  logic          result_valid;
  logic          result_ready = 1'b0;
  jlf_pkg::out_t result;

  joint_link_framer_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Behavioral copy of the block state.
  logic [2:0] frame_count = 3'd0;
  logic [7:0] payload_hold [4] = '{default: '0};
  logic [9:0] joint_pos [4] = '{default: '0};
  logic [9:0] joint_cmd [4] = '{default: '0};

  jlf_pkg::out_t expected_words [$];
  row_check_t    row_checks [$];
  int            mismatches = 0;
  int            burst_left = 0;

  function automatic jlf_pkg::out_t tx_word(logic [7:0] b, logic lst);
    jlf_pkg::out_t r;
    r = '0;
    r.kind = jlf_pkg::KIND_TX;
    r.tx_byte = b;
    r.last = lst;
    return r;
  endfunction

  function automatic jlf_pkg::out_t pos_word(logic [9:0] a, logic [9:0] b, logic [9:0] c,
                                             logic [9:0] d);
    jlf_pkg::out_t r;
    r = '0;
    r.kind = jlf_pkg::KIND_POS;
    r.pos_a = a;
    r.pos_b = b;
    r.pos_c = c;
    r.pos_d = d;
    return r;
  endfunction

  // Fields that the mode does not use are left random.
  function automatic jlf_pkg::in_t any_word(logic [1:0] m);
    jlf_pkg::in_t w;
    w.mode = m;
    w.rx_byte = 8'($urandom_range(0, 255));
    w.joint = 2'($urandom_range(0, 3));
    w.torque = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic jlf_pkg::in_t rx_word(logic [7:0] b);
    jlf_pkg::in_t w;
    w = any_word(jlf_pkg::MODE_RX);
    w.rx_byte = b;
    return w;
  endfunction

  function automatic jlf_pkg::in_t torque_word(logic [1:0] j, logic [15:0] t);
    jlf_pkg::in_t w;
    w = any_word(jlf_pkg::MODE_TORQUE);
    w.joint = j;
    w.torque = t;
    return w;
  endfunction

  task automatic predict_word(input jlf_pkg::in_t w);
    int         diff;
    int         i;
    logic [7:0] low_bits;
    case (w.mode)
      jlf_pkg::MODE_RX: begin
        if (frame_count >= 3'd1 && frame_count <= 3'd4) begin
          payload_hold[2'(frame_count - 3'd1)] = w.rx_byte;
          frame_count = frame_count + 3'd1;
        end else if (frame_count == 3'd5) begin
          for (i = 0; i < 4; i++)
            joint_pos[i] = {payload_hold[i], w.rx_byte[7 - 2 * i -: 2]};
          expected_words.push_back(pos_word(joint_pos[0], joint_pos[1], joint_pos[2],
                                            joint_pos[3]));
          frame_count = 3'd0;
        end else begin
          // Any count outside the payload range means hunting for a header.
          frame_count = (w.rx_byte == jlf_pkg::FRAME_HEADER) ? 3'd1 : 3'd0;
        end
      end
      jlf_pkg::MODE_TORQUE: begin
        diff = int'(joint_pos[w.joint]) - int'(w.torque);
        if (diff > int'(jlf_pkg::POS_MAX))
          diff = int'(jlf_pkg::POS_MAX);
        else if (diff < 0)
          diff = 0;
        joint_cmd[w.joint] = diff[9:0];
      end
      jlf_pkg::MODE_SEND: begin
        low_bits = '0;
        expected_words.push_back(tx_word(jlf_pkg::FRAME_HEADER, 1'b0));
        for (i = 0; i < 4; i++) begin
          expected_words.push_back(tx_word(joint_cmd[i][9:2], 1'b0));
          low_bits[7 - 2 * i -: 2] = joint_cmd[i][1:0];
        end
        expected_words.push_back(tx_word(low_bits, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string why, input jlf_pkg::out_t want,
                               input jlf_pkg::out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch (%s): expected kind=%0d tx=%02h last=%0d pos=%0d/%0d/%0d/%0d,",
               why, want.kind, want.tx_byte, want.last, want.pos_a, want.pos_b,
               want.pos_c, want.pos_d,
               " got kind=%0d tx=%02h last=%0d pos=%0d/%0d/%0d/%0d",
               got.kind, got.tx_byte, got.last, got.pos_a, got.pos_b, got.pos_c,
               got.pos_d);
  endtask

  // Prediction and checking share one process so that a word taken and a word
  // delivered at the same edge are handled in a fixed order.
  always @(posedge clk) begin : check_results
    row_check_t    chk;
    jlf_pkg::out_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        chk = row_checks.pop_front();
        predict_word(item);
        if (chk.typed)
          expected_words[$] = chk.res;
      end
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          note_mismatch("unexpected word", '0, result);
        end else begin
          want = expected_words.pop_front();
          if (result.kind !== want.kind || result.tx_byte !== want.tx_byte ||
              result.last !== want.last || result.pos_a !== want.pos_a ||
              result.pos_b !== want.pos_b || result.pos_c !== want.pos_c ||
              result.pos_d !== want.pos_d)
            note_mismatch("wrong field", want, result);
        end
      end
    end
  end

  // The receiver switches between stall styles each time style_cycle wraps.
  int         style_cycle = 0;
  logic [1:0] ready_style = 2'd0;
  logic [7:0] ready_pattern = 8'hff;

  always @(posedge clk) begin
    if (style_cycle == 0) begin
      ready_style = 2'($urandom_range(0, 3));
      ready_pattern = 8'($urandom_range(0, 255)) | 8'h01;
    end
    style_cycle = (style_cycle + 1) % 48;
    case (ready_style)
      2'd0: result_ready <= 1'b1;
      2'd1: result_ready <= 1'($urandom_range(0, 1));
      2'd2: result_ready <= ready_pattern[style_cycle % 8];
      default: result_ready <= (style_cycle % 32) >= 12;
    endcase
  end

  task automatic drive_word(input jlf_pkg::in_t w, input logic typed,
                            input jlf_pkg::out_t res);
    row_checks.push_back('{typed, res});
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // Sender bursts: short bursts with short gaps, now and then a long run or a long gap.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) :
                                                 $urandom_range(0, 5);
    end
  endtask

  task automatic drive_plain(input jlf_pkg::in_t w);
    drive_word(w, 1'b0, '0);
    pace();
  endtask

  initial begin : stimulus
    dir_row_t     rows [$];
    int           produced;
    int           choice;
    int           k;
    int           t;
    jlf_pkg::in_t w;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Send straight after reset: all commands are zero.
    rows.push_back('{any_word(jlf_pkg::MODE_SEND), 1'b1, tx_word(8'h00, 1'b1)});
    // A non-header byte while hunting is dropped.
    rows.push_back('{rx_word(8'h00), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{rx_word(jlf_pkg::FRAME_HEADER), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{rx_word(8'hff), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{rx_word(8'h00), 1'b0, jlf_pkg::out_t'(0)});
    // A header value inside the payload is plain data.
    rows.push_back('{rx_word(jlf_pkg::FRAME_HEADER), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{rx_word(8'h80), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{rx_word(8'hff), 1'b1, pos_word(10'd1023, 10'd3, 10'd263, 10'd515)});
    // Torque extremes: saturation at both ends, zero, and minus one.
    rows.push_back('{torque_word(2'd0, 16'h7fff), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{torque_word(2'd1, 16'h8000), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{torque_word(2'd2, 16'h0000), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{torque_word(2'd3, 16'hffff), 1'b0, jlf_pkg::out_t'(0)});
    // The unused mode changes nothing.
    rows.push_back('{rx_word(jlf_pkg::FRAME_HEADER) | {MODE_UNUSED, 26'd0}, 1'b0,
                     jlf_pkg::out_t'(0)});
    rows.push_back('{any_word(jlf_pkg::MODE_SEND), 1'b1, tx_word(8'h3c, 1'b1)});
    for (k = 0; k < 5; k++)
      rows.push_back('{rx_word(jlf_pkg::FRAME_HEADER), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{rx_word(8'h00), 1'b1, pos_word(10'd260, 10'd260, 10'd260, 10'd260)});
    rows.push_back('{jlf_pkg::in_t'({MODE_UNUSED, 26'h3ffffff}), 1'b0, jlf_pkg::out_t'(0)});
    // Exactly reaching the top, and one count below zero.
    rows.push_back('{torque_word(2'd0, 16'hfd05), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{torque_word(2'd1, 16'd261), 1'b0, jlf_pkg::out_t'(0)});
    rows.push_back('{any_word(jlf_pkg::MODE_SEND), 1'b0, jlf_pkg::out_t'(0)});

    foreach (rows[i]) begin
      drive_word(rows[i].w, rows[i].typed, rows[i].res);
      pace();
    end

    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 9);
      if (choice <= 3) begin
        drive_plain(rx_word(jlf_pkg::FRAME_HEADER));
        produced++;
        for (k = 0; k < 5; k++) begin
          // Now and then a command or a send lands in the middle of a frame.
          if ($urandom_range(0, 15) == 0) begin
            drive_plain(any_word(($urandom_range(0, 1) != 0) ? jlf_pkg::MODE_TORQUE :
                                                               jlf_pkg::MODE_SEND));
            produced++;
          end
          case ($urandom_range(0, 7))
            0: drive_plain(rx_word(8'h00));
            1: drive_plain(rx_word(8'hff));
            2: drive_plain(rx_word(jlf_pkg::FRAME_HEADER));
            default: drive_plain(any_word(jlf_pkg::MODE_RX));
          endcase
          produced++;
        end
      end else if (choice <= 5) begin
        w = any_word(jlf_pkg::MODE_TORQUE);
        if ($urandom_range(0, 1) != 0) begin
          t = $urandom_range(0, 2200);
          w.torque = 16'(t - 1100);
        end
        drive_plain(w);
        produced++;
      end else if (choice <= 7) begin
        drive_plain(any_word(jlf_pkg::MODE_SEND));
        produced++;
      end else if (choice == 8) begin
        drive_plain(any_word(jlf_pkg::MODE_RX));
        produced++;
      end else begin
        drive_plain(any_word(MODE_UNUSED));
        produced++;
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== joint_link_framer_top.f =====
rtl/jlf_pkg.sv
rtl/jlf_front.sv
rtl/jlf_queue.sv
rtl/jlf_back.sv
rtl/joint_link_framer_top.sv
tb/tb_joint_link_framer_top.sv
